// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
// Include guard keeps a second inclusion harmless.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequence is checked on the clock edge after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/core/qss_hs3_pkg.sv =====
// Package for the three-input hybrid switch: number formats, codes and types.
// Used by the interfaces, the top level and the checker.
package qss_hs3_pkg;
  localparam int VAL_W = 64;
  localparam int TIME_W = 63;
  localparam logic [TIME_W-1:0] T_INF = {TIME_W{1'b1}};
  localparam logic signed [VAL_W-1:0] S_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] S_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic OP_EXT = 1'b0;
  localparam logic OP_INT = 1'b1;

  typedef struct packed {
    logic                    op;
    logic [1:0]              port;
    logic [TIME_W-1:0]       elapsed_time;
    logic signed [VAL_W-1:0] in_value;
    logic signed [VAL_W-1:0] in_slope;
    logic signed [VAL_W-1:0] in_curvature;
  } in_item_t;

  typedef struct packed {
    logic                    emitted;
    logic signed [VAL_W-1:0] out_value;
    logic signed [VAL_W-1:0] out_slope;
    logic signed [VAL_W-1:0] out_curvature;
    logic [TIME_W-1:0]       time_advance;
  } out_item_t;

  function automatic logic signed [VAL_W-1:0] sadd(logic signed [VAL_W-1:0] a,
                                                   logic signed [VAL_W-1:0] b);
    logic signed [VAL_W:0] r;
    r = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    if (r[VAL_W] != r[VAL_W-1]) return r[VAL_W] ? S_MIN : S_MAX;
    return r[VAL_W-1:0];
  endfunction

  function automatic logic signed [VAL_W-1:0] ssub(logic signed [VAL_W-1:0] a,
                                                   logic signed [VAL_W-1:0] b);
    logic signed [VAL_W:0] r;
    r = {a[VAL_W-1], a} - {b[VAL_W-1], b};
    if (r[VAL_W] != r[VAL_W-1]) return r[VAL_W] ? S_MIN : S_MAX;
    return r[VAL_W-1:0];
  endfunction

  function automatic logic [VAL_W-1:0] mag(logic signed [VAL_W-1:0] x);
    return x[VAL_W-1] ? (~x + 64'd1) : x;
  endfunction

  function automatic logic signed [VAL_W-1:0] from_mag(logic neg, logic [VAL_W-1:0] m);
    if (!neg) return m[VAL_W-1] ? S_MAX : m;
    if (m[VAL_W-1]) return S_MIN;
    return ~m + 64'd1;
  endfunction

  function automatic logic [TIME_W-1:0] pos_time(logic signed [VAL_W-1:0] s);
    return (s[VAL_W-1] || (s[TIME_W-1:0] == T_INF)) ? T_INF : s[TIME_W-1:0];
  endfunction
endpackage

// ===== rtl/core/qss_hs3_in_if.sv =====
// Input channel interface of the hybrid switch; carries one event item.
// Depends on qss_hs3_pkg.
interface qss_hs3_in_if;
  import qss_hs3_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/qss_hs3_out_if.sv =====
// Result channel interface of the hybrid switch; carries one result item.
// Depends on qss_hs3_pkg.
interface qss_hs3_out_if;
  import qss_hs3_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/qss_hybrid_switch_three_input_top.sv =====
// Top level of the three-input hybrid switch for quantized state simulation.
// Depends on qss_hs3_pkg and the two channel interfaces.
//
//   channel   direction  content
//   in_ch     sink       op, port, elapsed_time, in_value, in_slope, in_curvature
//   out_ch    source     emitted, out_value, out_slope, out_curvature, time_advance
//   cfg_*     write      switch_level (signed Q32.32)
//
// One item is worked on at a time on a shared multiplier (32x32 partial products per
// 64x64 product), a restoring divider (one bit per cycle) and a square root (one bit per
// outer step, squaring on the same multiplier) under a micro-coded sequencer.
// Reset is synchronous and active low; no new item is taken while a result waits.
module qss_hybrid_switch_three_input_top #(
  parameter int FRAC_BITS = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  qss_hs3_in_if.sink                             in_ch,
  qss_hs3_out_if.source                          out_ch,
  input  logic                                   cfg_we,
  input  logic signed [qss_hs3_pkg::VAL_W-1:0]   cfg_wdata
);
  import qss_hs3_pkg::*;

  // Sequencer states. Each arithmetic step is started in ST_OP and its result
  // is collected by the next micro-operation once the sequencer is back in ST_OP.
  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_OP   = 7'b0000010,
    ST_MUL  = 7'b0000100,
    ST_DIV  = 7'b0001000,
    ST_SQRT = 7'b0010000,
    ST_SQM  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

  // Micro-operations. Each names one step of the event algorithms.
  typedef enum logic [5:0] {
    U_ADV_START, U_ADV_M1, U_ADV_M2, U_ADV_M3, U_ADV_M4, U_ADV_END,
    U_EXT_LOAD, U_CTL_START, U_CTL_AC, U_CTL_BB, U_CTL_DISC, U_CTL_SQRT,
    U_CTL_D1, U_CTL_D2, U_CTL_LIN, U_CTL_FIN, U_DATA_FIN,
    U_INT_START, U_INT_DIV, U_INT_FIN, U_DONE
  } uop_t;

  typedef enum logic [1:0] {
    K_EXT, K_INT_EMIT, K_INT_STORE
  } kind_t;

  state_t state_r, state_nxt;
  uop_t   uop_r;
  kind_t  kind_r;

  logic signed [VAL_W-1:0] tv_r [3];
  logic signed [VAL_W-1:0] ts_r [3];
  logic signed [VAL_W-1:0] tc_r [3];
  logic [TIME_W-1:0]       tte_r, cross_r;
  logic [1:0]              sel_r;
  logic                    pend_r;
  logic signed [VAL_W-1:0] level_r;

  in_item_t                item_r;
  logic [1:0]              idx_r;     // trajectory being advanced
  logic signed [VAL_W-1:0] t_r;       // advance time
  logic signed [VAL_W-1:0] acc_r, tmp_r, a_r, b_r, c_r, s1_r, s2_r;
  logic                    ov_r, ph_r;
  out_item_t               res_r;
  logic                    res_v_r;

  // Shared multiplier: unsigned 64x64 over four 32x32 partial products.
  logic [VAL_W-1:0]   ma_r, mb_r;
  logic               mneg_r;
  logic [127:0]       macc_r;
  logic [1:0]         mcnt_r;
  logic [63:0]        pp;
  logic [31:0]        pa, pb;
  logic signed [VAL_W-1:0] mres;

  // Shared divider.
  logic [VAL_W-1:0]   dd_r, dlo_r, dr_r, dq_r;
  logic               dneg_r;
  logic [6:0]         dcnt_r;
  logic [VAL_W:0]     dsh;

  // Square root: one result bit per outer step, c*c via the multiplier.
  logic [VAL_W-1:0]   sq_r, sqn_r;
  logic [6:0]         sbit_r;

  assign pa = mcnt_r[0] ? ma_r[63:32] : ma_r[31:0];
  assign pb = mcnt_r[1] ? mb_r[63:32] : mb_r[31:0];
  assign pp = pa * pb;

  always_comb begin
    logic [127:0] sh;
    sh = macc_r >> FRAC_BITS;
    if (sh[127:VAL_W] != '0) mres = mneg_r ? S_MIN : S_MAX;
    else mres = from_mag(mneg_r, sh[VAL_W-1:0]);
  end

  assign dsh = {dr_r, dlo_r[VAL_W-1]};

  // Wider-than-word compare for the square root: c*c against x << FRAC_BITS.
  logic [127:0] sq_tgt;
  assign sq_tgt = {64'd0, sqn_r} << FRAC_BITS;

  // Advance value helpers.
  logic signed [VAL_W-1:0] cur_v, cur_s, cur_c;
  assign cur_v = tv_r[idx_r];
  assign cur_s = ts_r[idx_r];
  assign cur_c = tc_r[idx_r];

  logic [1:0] nxt_idx;
  logic       adv_last;
  logic [1:0] emit_sel;
  assign emit_sel = sel_r & 2'b10;

  // Skip the port being loaded on an external event; a single trajectory on emit.
  always_comb begin
    nxt_idx = idx_r + 2'd1;
    if (kind_r == K_EXT && nxt_idx == item_r.port) nxt_idx = nxt_idx + 2'd1;
    adv_last = (kind_r == K_INT_EMIT) || (nxt_idx == 2'd3);
  end

  logic signed [VAL_W-1:0] u1;
  assign u1 = tv_r[1];

  logic signed [VAL_W-1:0] lvl_c;
  assign in_ch.ready  = (state_r == ST_IDLE) && !res_v_r;
  assign out_ch.valid = res_v_r;
  assign out_ch.data  = res_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_ch.valid && in_ch.ready) state_nxt = ST_OP;
      ST_MUL:  if (mcnt_r == 2'd3) state_nxt = ST_OP;
      ST_DIV:  if (dcnt_r == 7'd63) state_nxt = ST_OP;
      ST_SQM:  if (mcnt_r == 2'd3) state_nxt = (sbit_r == 7'd0) ? ST_OP : ST_SQRT;
      ST_SQRT: state_nxt = ST_SQM;
      ST_OUT:  state_nxt = ST_IDLE;
      default: state_nxt = state_r;
    endcase
  end

  assign lvl_c = level_r;

  always_ff @(posedge clk) begin
    logic signed [VAL_W-1:0] nv, ns, disc, r1;
    logic [TIME_W-1:0] ct;
    logic [VAL_W-1:0] m, dm;
    out_item_t ro;
    if (!rst_n) begin
      state_r <= ST_IDLE;
      res_v_r <= 1'b0;
      level_r <= '0;
      for (int i = 0; i < 3; i++) begin
        tv_r[i] <= '0; ts_r[i] <= '0; tc_r[i] <= '0;
      end
      tte_r   <= T_INF;
      cross_r <= T_INF;
      sel_r   <= 2'd0;
      pend_r  <= 1'b0;
      uop_r   <= U_DONE;
      kind_r  <= K_EXT;
    end else begin
      // The micro-operations set the state themselves while in ST_OP.
      if (state_r != ST_OP) state_r <= state_nxt;
      if (cfg_we) level_r <= cfg_wdata;
      if (out_ch.valid && out_ch.ready) res_v_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            item_r <= in_ch.data;
            ro = '0;
            ro.emitted = in_ch.data.op;
            if (in_ch.data.op == OP_INT) begin
              if (tte_r == '0) begin
                ro.out_value     = tv_r[emit_sel];
                ro.out_slope     = ts_r[emit_sel];
                ro.out_curvature = tc_r[emit_sel];
                uop_r <= U_INT_FIN;
              end else begin
                kind_r <= K_INT_EMIT;
                idx_r  <= 2'd2 - emit_sel;
                t_r    <= {1'b0, tte_r};
                uop_r  <= U_ADV_START;
              end
            end else if (in_ch.data.port == 2'd3) begin
              uop_r <= U_DONE;
            end else begin
              kind_r <= K_EXT;
              idx_r  <= (in_ch.data.port == 2'd0) ? 2'd1 : 2'd0;
              t_r    <= {1'b0, in_ch.data.elapsed_time};
              uop_r  <= U_ADV_START;
            end
            res_r <= ro;
          end
        end

        ST_MUL: begin
          macc_r <= macc_r + ({64'd0, pp} << (32 * (mcnt_r[0] + mcnt_r[1])));
          mcnt_r <= mcnt_r + 2'd1;
        end

        ST_DIV: begin
          dlo_r <= {dlo_r[VAL_W-2:0], 1'b0};
          if (dr_r[VAL_W-1] || dsh[VAL_W-1:0] >= dd_r) begin
            dr_r <= dsh[VAL_W-1:0] - dd_r;
            dq_r <= {dq_r[VAL_W-2:0], 1'b1};
          end else begin
            dr_r <= dsh[VAL_W-1:0];
            dq_r <= {dq_r[VAL_W-2:0], 1'b0};
          end
          dcnt_r <= dcnt_r + 7'd1;
        end

        ST_SQRT: begin
          ma_r   <= sq_r | (64'd1 << sbit_r[5:0]);
          mb_r   <= sq_r | (64'd1 << sbit_r[5:0]);
          macc_r <= '0;
          mcnt_r <= 2'd0;
        end

        ST_SQM: begin
          macc_r <= macc_r + ({64'd0, pp} << (32 * (mcnt_r[0] + mcnt_r[1])));
          mcnt_r <= mcnt_r + 2'd1;
          if (mcnt_r == 2'd3) begin
            if ((macc_r + ({64'd0, pp} << 64)) <= sq_tgt) sq_r <= ma_r;
            sbit_r <= sbit_r - 7'd1;
          end
        end

        ST_OP: begin
          case (uop_r)
            U_ADV_START: begin   // curvature * t
              ma_r <= mag(cur_c); mb_r <= mag(t_r);
              mneg_r <= cur_c[VAL_W-1] ^ t_r[VAL_W-1];
              macc_r <= '0; mcnt_r <= 2'd0;
              state_r <= ST_MUL; uop_r <= U_ADV_M1;
            end
            U_ADV_M1: begin      // (curvature*t) * t
              ma_r <= mag(mres); mb_r <= mag(t_r);
              mneg_r <= mres[VAL_W-1] ^ t_r[VAL_W-1];
              macc_r <= '0; mcnt_r <= 2'd0;
              state_r <= ST_MUL; uop_r <= U_ADV_M2;
            end
            U_ADV_M2: begin      // slope * t
              tmp_r <= mres;
              ma_r <= mag(cur_s); mb_r <= mag(t_r);
              mneg_r <= cur_s[VAL_W-1] ^ t_r[VAL_W-1];
              macc_r <= '0; mcnt_r <= 2'd0;
              state_r <= ST_MUL; uop_r <= U_ADV_M3;
            end
            U_ADV_M3: begin      // (2*curvature) * t
              acc_r <= sadd(sadd(cur_v, mres), tmp_r);
              nv = sadd(cur_c, cur_c);
              ma_r <= mag(nv); mb_r <= mag(t_r);
              mneg_r <= nv[VAL_W-1] ^ t_r[VAL_W-1];
              macc_r <= '0; mcnt_r <= 2'd0;
              state_r <= ST_MUL; uop_r <= U_ADV_M4;
            end
            U_ADV_M4: begin
              ns = sadd(cur_s, mres);
              if (kind_r == K_INT_EMIT) begin
                ro = res_r;
                ro.out_value     = acc_r;
                ro.out_slope     = ns;
                ro.out_curvature = cur_c;
                res_r <= ro;
                // Re-run the advance over all three trajectories to store.
                kind_r <= K_INT_STORE;
                idx_r  <= 2'd0;
                uop_r  <= U_ADV_START;
              end else begin
                tv_r[idx_r] <= acc_r;
                ts_r[idx_r] <= ns;
                if (adv_last) uop_r <= U_ADV_END;
                else begin
                  idx_r <= nxt_idx;
                  uop_r <= U_ADV_START;
                end
              end
            end
            U_ADV_END: begin
              uop_r <= (kind_r == K_EXT) ? U_EXT_LOAD : U_INT_START;
            end
            U_EXT_LOAD: begin
              tv_r[item_r.port] <= item_r.in_value;
              ts_r[item_r.port] <= item_r.in_slope;
              tc_r[item_r.port] <= item_r.in_curvature;
              uop_r <= (item_r.port == 2'd1) ? U_CTL_START : U_DATA_FIN;
            end
            U_CTL_START: begin
              a_r <= tc_r[1]; b_r <= ts_r[1];
              c_r <= ssub(tv_r[1], lvl_c);
              s1_r <= S_MAX; s2_r <= S_MAX; ov_r <= 1'b0;
              nv = ssub(tv_r[1], lvl_c);
              if (tc_r[1] == '0) begin
                if (ts_r[1] != '0) begin
                  nv = ssub('0, nv);
                  ph_r <= 1'b0;
                  tmp_r <= nv; acc_r <= ts_r[1];
                  uop_r <= U_CTL_LIN;
                end else uop_r <= U_CTL_FIN;
              end else begin
                ma_r <= mag(tc_r[1]); mb_r <= mag(nv);
                mneg_r <= tc_r[1][VAL_W-1] ^ nv[VAL_W-1];
                macc_r <= '0; mcnt_r <= 2'd0;
                state_r <= ST_MUL; uop_r <= U_CTL_AC;
              end
            end
            U_CTL_AC: begin
              tmp_r <= mres;
              ma_r <= mag(b_r); mb_r <= mag(b_r); mneg_r <= 1'b0;
              macc_r <= '0; mcnt_r <= 2'd0;
              state_r <= ST_MUL; uop_r <= U_CTL_BB;
            end
            U_CTL_BB: begin
              disc = ssub(mres, sadd(sadd(tmp_r, tmp_r), sadd(tmp_r, tmp_r)));
              if (disc[VAL_W-1]) begin
                ov_r <= 1'b1;
                uop_r <= U_CTL_FIN;
              end else begin
                sqn_r <= disc; sq_r <= '0; sbit_r <= 7'd63;
                state_r <= ST_SQRT; uop_r <= U_CTL_SQRT;
              end
            end
            U_CTL_SQRT: begin
              // All bits down to bit 0 are finished; this is the final root.
              // Both numerators are halved, truncating toward zero.
              nv = ssub('0, b_r);
              r1 = sadd(nv, sq_r);
              tmp_r <= ssub(nv, sq_r) / 2;
              r1 = r1 / 2;
              ph_r <= 1'b0;
              acc_r <= r1;
              uop_r <= U_CTL_D1;
            end
            U_CTL_D1, U_CTL_D2, U_CTL_LIN, U_INT_DIV: begin
              // Start a division of acc_r by a_r (tmp_r by acc_r, the slope, in the linear case),
              // or collect its result on the second pass.
              if (!ph_r) begin
                nv = (uop_r == U_CTL_LIN) ? tmp_r : acc_r;
                ns = (uop_r == U_CTL_LIN) ? acc_r : a_r;
                m  = mag(nv); dm = mag(ns);
                dneg_r <= nv[VAL_W-1] ^ ns[VAL_W-1];
                ph_r <= 1'b1;
                if (ns == '0) begin
                  tmp_r <= nv[VAL_W-1] ? S_MIN : S_MAX;
                  ov_r  <= 1'b1;   // marks an immediate result
                end else if ((m >> (VAL_W - FRAC_BITS)) >= dm) begin
                  tmp_r <= (nv[VAL_W-1] ^ ns[VAL_W-1]) ? S_MIN : S_MAX;
                  ov_r  <= 1'b1;
                end else begin
                  dd_r <= dm; dr_r <= m >> (VAL_W - FRAC_BITS);
                  dlo_r <= m << FRAC_BITS; dq_r <= '0; dcnt_r <= '0;
                  ov_r <= 1'b0;
                  state_r <= ST_DIV;
                end
                if (uop_r == U_CTL_D1) s2_r <= tmp_r;  // keep the second numerator
              end else begin
                ph_r <= 1'b0; ov_r <= 1'b0;
                nv = ov_r ? tmp_r : from_mag(dneg_r, dq_r);
                case (uop_r)
                  U_CTL_D1: begin
                    s1_r <= nv; acc_r <= s2_r; uop_r <= U_CTL_D2;
                  end
                  U_CTL_D2: begin
                    s2_r <= nv; uop_r <= U_CTL_FIN;
                  end
                  U_CTL_LIN: begin
                    s1_r <= nv; uop_r <= U_CTL_FIN;
                  end
                  default: begin
                    tte_r <= pos_time(nv); cross_r <= pos_time(nv);
                    uop_r <= U_INT_FIN;
                  end
                endcase
              end
            end
            U_CTL_FIN: begin
              if (ov_r) ct = T_INF;
              else if (s1_r > 0 && (s1_r < s2_r || s2_r < 0)) ct = pos_time(s1_r);
              else if (s2_r > 0) ct = pos_time(s2_r);
              else ct = T_INF;
              cross_r <= ct;
              if (tte_r == item_r.elapsed_time &&
                  ((u1 > lvl_c && sel_r == 2'd0) || (u1 < lvl_c && sel_r == 2'd2))) begin
                tte_r <= '0;
              end else if ((u1 > lvl_c && sel_r == 2'd2) || (u1 < lvl_c && sel_r == 2'd0)) begin
                sel_r <= 2'd2 - sel_r; pend_r <= 1'b1; tte_r <= '0;
              end else tte_r <= ct;
              ov_r <= 1'b0;
              uop_r <= U_DONE;
            end
            U_DATA_FIN: begin
              ct = cross_r;
              if (cross_r != T_INF)
                ct = (cross_r > item_r.elapsed_time) ? cross_r - item_r.elapsed_time : '0;
              cross_r <= ct;
              if (tte_r == item_r.elapsed_time) tte_r <= '0;
              else if (item_r.elapsed_time == '0)
                tte_r <= ({1'b0, sel_r} == {1'b0, item_r.port} || pend_r) ? '0 : ct;
              else if (u1 > lvl_c && item_r.port == 2'd0) begin
                tte_r <= '0; sel_r <= 2'd0;
              end else if (u1 < lvl_c && item_r.port == 2'd2) begin
                tte_r <= '0; sel_r <= 2'd2;
              end else tte_r <= ct;
              uop_r <= U_DONE;
            end
            U_INT_START: begin
              sel_r <= 2'd2 - emit_sel;
              if (tc_r[1] != '0 && ts_r[1] != '0 && (tc_r[1][VAL_W-1] != ts_r[1][VAL_W-1])) begin
                acc_r <= ssub('0, ts_r[1]); a_r <= tc_r[1]; ph_r <= 1'b0;
                uop_r <= U_INT_DIV;
              end else begin
                tte_r <= T_INF; cross_r <= T_INF;
                uop_r <= U_INT_FIN;
              end
            end
            U_INT_FIN: begin
              if (tte_r == '0 && kind_r != K_INT_STORE) tte_r <= cross_r;
              pend_r <= 1'b0;
              kind_r <= K_EXT;
              uop_r <= U_DONE;
            end
            default: begin
              state_r <= ST_OUT;
            end
          endcase
        end

        ST_OUT: begin
          res_r.time_advance <= tte_r;
          res_v_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== rtl/core/qss_hs3_checker.sv =====
// Port-level checker for the hybrid switch, bound to the top level.
// Depends on qss_hs3_pkg, the channel interfaces and assert_macros.svh.
`include "assert_macros.svh"
module qss_hs3_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input qss_hs3_pkg::out_item_t        out_data
);
  import qss_hs3_pkg::*;
  `CHK_IMPLY(a_busy, clk, rst_n, out_valid, !in_ready, "input taken while a result waits")
  `CHK_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready, "two items in a row")
  `CHK_IMPLY(a_zero_when_silent, clk, rst_n, out_valid && !out_data.emitted,
    out_data.out_value == '0 && out_data.out_slope == '0, "payload on silent result")
  `CHK_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data),
    "result changed while stalled")
endmodule

bind qss_hybrid_switch_three_input_top qss_hs3_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);

// ===== verif/testbench.sv =====
// Self-checking testbench for the three-input hybrid switch top level.
// Depends on qss_hs3_pkg, qss_hs3_in_if, qss_hs3_out_if and the top module.
// A directed table runs first, then phases of random events under several thresholds.
module testbench;
  import qss_hs3_pkg::*;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [TIME_W-1:0] tim_t;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t res;
  } row_t;

  localparam val_t ONE = 64'sh0000_0001_0000_0000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  val_t cfg_wdata;

  qss_hs3_in_if  in_ch ();
  qss_hs3_out_if out_ch ();

  qss_hybrid_switch_three_input_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the switch: threshold, three trajectories and timing state.
  val_t thr_level;
  val_t trj_val [3];
  val_t trj_slp [3];
  val_t trj_crv [3];
  tim_t next_event;
  tim_t cross_at;
  int   sel_port;
  bit   change_flag;

  out_item_t pending_results[$];
  row_t      plan[$];
  int        errors;
  int        mismatches;
  bit        quiet;
  bit        hold_req;

  // Saturating helpers in Q32.32.
  function automatic val_t sat_sign(bit neg, logic [63:0] m);
    if (!neg) return m[63] ? S_MAX : val_t'(m);
    if (m[63]) return S_MIN;
    return -val_t'(m);
  endfunction

  function automatic logic [63:0] abs_of(val_t x);
    return x[63] ? -x : x;
  endfunction

  function automatic val_t sat_add(val_t a, val_t b);
    logic signed [64:0] r;
    r = {a[63], a} + {b[63], b};
    if (r[64] != r[63]) return r[64] ? S_MIN : S_MAX;
    return r[63:0];
  endfunction

  function automatic val_t sat_sub(val_t a, val_t b);
    logic signed [64:0] r;
    r = {a[63], a} - {b[63], b};
    if (r[64] != r[63]) return r[64] ? S_MIN : S_MAX;
    return r[63:0];
  endfunction

  function automatic val_t fx_mul(val_t a, val_t b);
    logic [127:0] p;
    bit neg;
    neg = a[63] ^ b[63];
    p = {64'd0, abs_of(a)} * {64'd0, abs_of(b)};
    if (|p[127:96]) return neg ? S_MIN : S_MAX;
    return sat_sign(neg, p[95:32]);
  endfunction

  function automatic val_t fx_div(val_t n, val_t d);
    logic [63:0] mn, md;
    logic [127:0] q;
    bit neg;
    if (d == 0) return n[63] ? S_MIN : S_MAX;
    neg = n[63] ^ d[63];
    mn = abs_of(n);
    md = abs_of(d);
    if ((mn >> 32) >= md) return neg ? S_MIN : S_MAX;
    q = {32'd0, mn, 32'd0} / {64'd0, md};
    return sat_sign(neg, q[63:0]);
  endfunction

  function automatic val_t fx_sqrt(val_t x);
    logic [127:0] n, sq;
    logic [63:0] r, c;
    n = {32'd0, x, 32'd0};
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      sq = {64'd0, c} * {64'd0, c};
      if (sq <= n) r = c;
    end
    return val_t'(r);
  endfunction

  // Negative values and anything at or above the infinity code become infinity.
  function automatic tim_t to_time(val_t s);
    return (s[63] || s[62:0] == T_INF) ? T_INF : s[62:0];
  endfunction

  // Value and slope of trajectory k after time t.
  function automatic void extrapolate(int k, val_t t, output val_t v, output val_t s);
    val_t pt;
    pt = fx_mul(trj_crv[k], t);
    v = sat_add(sat_add(trj_val[k], fx_mul(trj_slp[k], t)), fx_mul(pt, t));
    s = sat_add(trj_slp[k], fx_mul(sat_add(trj_crv[k], trj_crv[k]), t));
  endfunction

  // Threshold crossing of the control trajectory and the resulting switch decision.
  function automatic void solve_control(tim_t e);
    val_t a, b, c, u1, s1, s2, ac, disc, r, nb;
    bit none;
    int sw;
    a = trj_crv[1];
    b = trj_slp[1];
    c = sat_sub(trj_val[1], thr_level);
    u1 = trj_val[1];
    s1 = S_MAX;
    s2 = S_MAX;
    none = 0;
    sw = sel_port;
    if (a == 0) begin
      if (b != 0) s1 = fx_div(sat_sub(0, c), b);
    end else begin
      ac = fx_mul(a, c);
      disc = sat_sub(fx_mul(b, b), sat_add(sat_add(ac, ac), sat_add(ac, ac)));
      if (disc < 0) begin
        none = 1;
      end else begin
        r = fx_sqrt(disc);
        nb = sat_sub(0, b);
        s1 = fx_div(sat_add(nb, r) / 2, a);
        s2 = fx_div(sat_sub(nb, r) / 2, a);
      end
    end
    if (none) cross_at = T_INF;
    else if (s1 > 0 && (s1 < s2 || s2 < 0)) cross_at = to_time(s1);
    else if (s2 > 0) cross_at = to_time(s2);
    else cross_at = T_INF;

    if (next_event == e &&
        ((u1 > thr_level && sw == 0) || (u1 < thr_level && sw == 2))) begin
      next_event = 0;
    end else if ((u1 > thr_level && sw == 2) || (u1 < thr_level && sw == 0)) begin
      sel_port = 2 - sw;
      change_flag = 1;
      next_event = 0;
    end else begin
      next_event = cross_at;
    end
  endfunction

  // Updates the shadow state for one accepted event and returns its result.
  function automatic out_item_t switch_step(in_item_t it);
    out_item_t o;
    val_t v, s, c, t, a, b;
    int sw, k, p;
    o = '0;
    v = 0;
    s = 0;
    c = 0;
    p = it.port;
    if (it.op == OP_INT) begin
      sw = sel_port & 2;
      if (next_event == 0) begin
        v = trj_val[sw];
        s = trj_slp[sw];
        c = trj_crv[sw];
        next_event = cross_at;
      end else begin
        t = {1'b0, next_event};
        extrapolate(2 - sw, t, v, s);
        c = trj_crv[2 - sw];
        for (k = 0; k < 3; k++) extrapolate(k, t, trj_val[k], trj_slp[k]);
        b = trj_slp[1];
        a = trj_crv[1];
        if (a != 0 && b != 0 && a[63] != b[63]) next_event = to_time(fx_div(sat_sub(0, b), a));
        else next_event = T_INF;
        cross_at = next_event;
        sel_port = (sel_port == 2) ? 0 : 2;
      end
      change_flag = 0;
    end else if (p < 3) begin
      t = {1'b0, it.elapsed_time};
      for (k = 0; k < 3; k++)
        if (k != p) extrapolate(k, t, trj_val[k], trj_slp[k]);
      a = trj_val[1];
      trj_val[p] = it.in_value;
      trj_slp[p] = it.in_slope;
      trj_crv[p] = it.in_curvature;
      if (p == 1) begin
        solve_control(it.elapsed_time);
      end else begin
        // The control value seen by a data event is the one after advancing.
        a = trj_val[1];
        if (cross_at != T_INF)
          cross_at = (cross_at > it.elapsed_time) ? cross_at - it.elapsed_time : '0;
        if (next_event == it.elapsed_time) begin
          next_event = 0;
        end else if (it.elapsed_time == 0) begin
          next_event = (sel_port == p || change_flag) ? '0 : cross_at;
        end else if (a > thr_level && p == 0) begin
          next_event = 0;
          sel_port = 0;
        end else if (a < thr_level && p == 2) begin
          next_event = 0;
          sel_port = 2;
        end else begin
          next_event = cross_at;
        end
      end
    end
    o.emitted = it.op;
    o.out_value = v;
    o.out_slope = s;
    o.out_curvature = c;
    o.time_advance = next_event;
    return o;
  endfunction

  // Random coefficient: mostly a few units, sometimes extremes or all 64 bits.
  function automatic val_t pick_coef();
    logic [35:0] low;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return S_MAX;
          1: return S_MIN;
          2: return 0;
          default: return -1;
        endcase
      end
      1: return {$urandom, $urandom};
      2: return 0;
      default: begin
        low = 36'({$urandom, $urandom});
        return {{28{low[35]}}, low};
      end
    endcase
  endfunction

  function automatic tim_t pick_time();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return T_INF;
      2: return tim_t'({$urandom, $urandom});
      3, 4: return next_event;
      default: return tim_t'({$urandom_range(0, 3), $urandom});
    endcase
  endfunction

  function automatic in_item_t pick_event();
    in_item_t it;
    it.op = ($urandom_range(0, 9) < 3) ? OP_INT : OP_EXT;
    it.port = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    it.elapsed_time = pick_time();
    it.in_value = pick_coef();
    it.in_slope = pick_coef();
    it.in_curvature = ($urandom_range(0, 2) == 0) ? 0 : pick_coef();
    return it;
  endfunction

  task automatic add_row(logic op, logic [1:0] port, tim_t e, val_t v, val_t s, val_t c);
    row_t r;
    r.item = '{op, port, e, v, s, c};
    r.typed = 0;
    r.res = '0;
    plan.push_back(r);
  endtask

  // Offers one item, with an optional idle burst first, and records its expected result.
  task automatic send_event(in_item_t it, bit typed, out_item_t res);
    out_item_t pred;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17) - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    pred = switch_step(it);
    pending_results.push_back(typed ? res : pred);
  endtask

  // Lowers valid and waits until every expected result has been transferred.
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_level(val_t lv);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= lv;
    thr_level = lv;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: random stalls, one long hold-off on request, none when quiet.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (1999) @(negedge clk);
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17) - 1) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Every result transfer is compared with the oldest pending expectation.
  initial begin
    out_item_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          errors++;
          if (mismatches++ < 10) $display("Unexpected result transfer: %p", out_ch.data);
        end else begin
          want = pending_results.pop_front();
          if (out_ch.data !== want) begin
            errors++;
            if (mismatches++ < 10) begin
              $display("Mismatch exp: em=%0d v=%h s=%h c=%h ta=%h", want.emitted,
                       want.out_value, want.out_slope, want.out_curvature, want.time_advance);
              $display("         got: em=%0d v=%h s=%h c=%h ta=%h", out_ch.data.emitted,
                       out_ch.data.out_value, out_ch.data.out_slope,
                       out_ch.data.out_curvature, out_ch.data.time_advance);
            end
          end
        end
      end
    end
  end

  initial begin
    val_t levels [5];
    row_t r;
    errors = 0;
    mismatches = 0;
    quiet = 0;
    hold_req = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;

    // Shadow state matches the block after reset.
    thr_level = 0;
    for (int k = 0; k < 3; k++) begin
      trj_val[k] = 0;
      trj_slp[k] = 0;
      trj_crv[k] = 0;
    end
    next_event = T_INF;
    cross_at = T_INF;
    sel_port = 0;
    change_flag = 0;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    write_level(0);

    // Directed table. The first two rows follow straight from the reset state:
    // an internal event on zero trajectories, then an ignored event on port 3.
    r.item = '{OP_INT, 2'd0, '0, 0, 0, 0};
    r.typed = 1;
    r.res = '{1'b1, 0, 0, 0, T_INF};
    plan.push_back(r);
    r.item = '{OP_EXT, 2'd3, T_INF, S_MAX, S_MIN, S_MAX};
    r.res = '{1'b0, 0, 0, 0, T_INF};
    plan.push_back(r);
    add_row(OP_EXT, 2'd0, 0, S_MAX, S_MAX, S_MAX);
    add_row(OP_EXT, 2'd2, T_INF, S_MIN, S_MIN, S_MIN);
    add_row(OP_EXT, 2'd1, tim_t'(ONE), ONE, -ONE, 0);        // linear control, real crossing
    add_row(OP_INT, 2'd0, 0, 0, 0, 0);
    add_row(OP_EXT, 2'd1, 0, ONE, 0, ONE);           // negative discriminant
    add_row(OP_EXT, 2'd1, 0, -ONE, 0, ONE);          // two real roots
    add_row(OP_INT, 2'd0, 0, 0, 0, 0);
    add_row(OP_EXT, 2'd0, tim_t'(ONE), 2 * ONE, ONE, -ONE);
    add_row(OP_EXT, 2'd2, 0, -ONE, ONE, 0);
    add_row(OP_EXT, 2'd2, tim_t'(3 * ONE), ONE, ONE, ONE);   // crossing time floors at zero
    add_row(OP_INT, 2'd0, 0, 0, 0, 0);
    add_row(OP_EXT, 2'd1, tim_t'(ONE), ONE, S_MAX, S_MIN);   // saturating products
    add_row(OP_INT, 2'd0, 0, 0, 0, 0);
    add_row(OP_EXT, 2'd1, T_INF, 0, 0, 0);           // flat control, no crossing
    add_row(OP_EXT, 2'd0, tim_t'(ONE / 2), -1, 1, -1);
    add_row(OP_INT, 2'd0, 0, 0, 0, 0);
    add_row(OP_INT, 2'd0, 0, 0, 0, 0);
    foreach (plan[n]) send_event(plan[n].item, plan[n].typed, plan[n].res);
    drain();

    // Random phases, each under its own threshold. The second starts with a
    // long hold-off on the result side, and the last one runs without idling.
    levels[0] = S_MAX;
    levels[1] = S_MIN;
    levels[2] = ONE / 2;
    levels[3] = -3 * ONE;
    levels[4] = 0;
    for (int ph = 0; ph < 5; ph++) begin
      write_level(levels[ph]);
      if (ph == 1) hold_req = 1;
      if (ph == 4) quiet = 1;
      repeat (86) send_event(pick_event(), 0, '0);
      drain();
    end

    repeat (500) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/qss_hs3_pkg.sv
rtl/core/qss_hs3_in_if.sv
rtl/core/qss_hs3_out_if.sv
rtl/core/qss_hybrid_switch_three_input_top.sv
rtl/core/qss_hs3_checker.sv
verif/testbench.sv
